### design/orwa_pkg.sv
// Shared types and constants for the overwrite ring window average block.
package orwa_pkg;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_DROP  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam int COUNT_W = 4;
    localparam int MEAN_W  = 24;
    localparam int FRAC_W  = 8;
    localparam int OUT_W   = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

### design/orwa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module orwa_div #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### design/overwrite_ring_window_average_top.sv
// Top level of the ring window average: sample ring memory, running sum and result path.
//
//  Channel   Signals                    Payload
//  -------   -------------------------  ------------------------------------------
//  s_*       s_tvalid s_tready s_tdata  cmd [1:0], sample [SAMPLE_BITS+1:2]
//  m_*       m_tvalid m_tready m_tdata  status [0], count [4:1], mean [28:5]
//
// A command passes from the execute state through the bit-serial divide of the running sum
// by the count to the output state; the result is presented in the same cycle as the next
// command can be taken. A command that leaves the window empty skips the divide.
// One command is in work at a time; a finished result waits in the output register
// while the next command is taken, and the block stalls only when that register is full.
// Reset empties the window; sample memory contents are undefined until written.
module overwrite_ring_window_average_top #(
    parameter int QUEUE_SLOTS = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // cmd, sample
    input  logic [((SAMPLE_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // status, count, mean
    output logic [orwa_pkg::OUT_W-1:0]             m_tdata
);

    localparam int IDX_W  = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CNT_W  = IDX_W;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int DIV_W  = SUM_W + orwa_pkg::FRAC_W;
    localparam int MWIDE  = (DIV_W > orwa_pkg::MEAN_W) ? DIV_W : orwa_pkg::MEAN_W;
    localparam int CWIDE  = (CNT_W > orwa_pkg::COUNT_W) ? CNT_W : orwa_pkg::COUNT_W;
    localparam int PAD_W  = orwa_pkg::OUT_W - 1 - orwa_pkg::COUNT_W - orwa_pkg::MEAN_W;

    orwa_pkg::state_t state_reg;
    orwa_pkg::state_t state_next;

    logic [SAMPLE_BITS-1:0] sample_store [QUEUE_SLOTS];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    logic [1:0]             cmd_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   status_reg;
    logic                   status_next;
    logic [orwa_pkg::MEAN_W-1:0] mean_reg;

    logic                   m_valid_reg;
    logic [orwa_pkg::OUT_W-1:0] m_data_reg;

    logic                   accept;
    logic                   load_out;
    logic                   mem_we;
    logic                   full;
    logic                   div_start;
    logic                   div_done;
    logic [DIV_W-1:0]       quotient;
    logic [MWIDE-1:0]       mean_wide;
    logic [CWIDE-1:0]       count_wide;
    logic [IDX_W-1:0]       head_inc;
    logic [IDX_W-1:0]       tail_inc;

    assign accept   = s_tvalid && s_tready;
    assign head_inc = (head_reg == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
    assign full     = (count_reg == CNT_W'(QUEUE_SLOTS - 1));

    // Window update, evaluated in the execute state with the oldest sample in rd_data_reg.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        status_next = orwa_pkg::STATUS_OK;
        mem_we      = 1'b0;
        case (cmd_reg)
            orwa_pkg::CMD_PUSH:
            begin
                mem_we    = 1'b1;
                tail_next = tail_inc;
                if (full)
                begin
                    head_next = head_inc;
                    sum_next  = sum_reg - SUM_W'(rd_data_reg) + SUM_W'(sample_reg);
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + SUM_W'(sample_reg);
                end
            end
            orwa_pkg::CMD_DROP:
            begin
                if (count_reg == '0)
                begin
                    status_next = orwa_pkg::STATUS_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    sum_next   = sum_reg - SUM_W'(rd_data_reg);
                end
            end
            orwa_pkg::CMD_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                sum_next   = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            orwa_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = orwa_pkg::ST_EXEC;
                end
            end
            orwa_pkg::ST_EXEC:
            begin
                if (count_next != '0)
                begin
                    div_start  = 1'b1;
                    state_next = orwa_pkg::ST_DIV;
                end
                else
                begin
                    state_next = orwa_pkg::ST_OUT;
                end
            end
            orwa_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = orwa_pkg::ST_OUT;
                end
            end
            orwa_pkg::ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = orwa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = orwa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= orwa_pkg::ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == orwa_pkg::ST_EXEC)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The oldest sample is read on every transfer; it is used only by a drop or a full push.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= sample_store[head_reg];
        end
        if (state_reg == orwa_pkg::ST_EXEC && mem_we)
        begin
            sample_store[tail_reg] <= sample_reg;
        end
    end

    assign mean_wide  = MWIDE'(quotient);
    assign count_wide = CWIDE'(count_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tdata[1:0];
            sample_reg <= s_tdata[SAMPLE_BITS+1:2];
        end
        if (state_reg == orwa_pkg::ST_EXEC)
        begin
            status_reg <= status_next;
            mean_reg   <= '0;
        end
        else if (state_reg == orwa_pkg::ST_DIV && div_done)
        begin
            mean_reg <= mean_wide[orwa_pkg::MEAN_W-1:0];
        end
        if (load_out)
        begin
            m_data_reg <= {{PAD_W{1'b0}}, mean_reg,
                           count_wide[orwa_pkg::COUNT_W-1:0], status_reg};
        end
    end

    orwa_div #(
        .DIVIDEND_W(DIV_W),
        .DIVISOR_W (CNT_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend({sum_next, {orwa_pkg::FRAC_W{1'b0}}}),
        .divisor (count_next),
        .done    (div_done),
        .quotient(quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
